/* rtl/core/vap_pkg.sv */
package vap_pkg;

    localparam int DefIndexBits = 24;
    localparam int CfgIdxBits   = 3;
    localparam int CfgDataBits  = 32;
    localparam int QueueDepth   = 4;

    localparam logic [CfgIdxBits-1:0] REG_HAS_NORMALS   = 3'd0;
    localparam logic [CfgIdxBits-1:0] REG_NORMAL_COUNT  = 3'd1;
    localparam logic [CfgIdxBits-1:0] REG_HAS_COLORS    = 3'd2;
    localparam logic [CfgIdxBits-1:0] REG_HAS_TEXCOORDS = 3'd3;
    localparam logic [CfgIdxBits-1:0] REG_VERTEX_COUNT  = 3'd4;

    localparam logic [31:0] FloatOne = 32'h3F80_0000;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] nrm_x;
        logic [31:0] nrm_y;
        logic [31:0] nrm_z;
        logic [31:0] col_r;
        logic [31:0] col_g;
        logic [31:0] col_b;
        logic [31:0] col_a;
        logic [31:0] tex_u;
        logic [31:0] tex_v;
    } t_vtx_in;

    typedef struct packed {
        logic [31:0] out_pos_x;
        logic [31:0] out_pos_y;
        logic [31:0] out_pos_z;
        logic [31:0] out_nrm_x;
        logic [31:0] out_nrm_y;
        logic [31:0] out_nrm_z;
        logic [31:0] out_color;
        logic [31:0] out_texcoord;
    } t_vtx_out;

    // Classified vertex handed from the front end to the back end.
    typedef struct packed {
        t_vtx_in vtx;
        logic    use_nrm;
        logic    use_col;
        logic    use_tex;
    } t_job;

    // Color channel to byte: clamp, v*255 and +0.5 each rounded to binary32,
    // then truncate. The product is rounded to 24 significant bits first; the
    // sum is then held with 32 fraction bits, and its rounding can only matter
    // when it carries into the next integer.
    function automatic logic [7:0] unorm8(input logic [31:0] b);
        logic [7:0]  ex;
        logic [23:0] m;
        logic [31:0] p;
        logic        up;
        logic [32:0] keep;
        logic [40:0] xf;
        logic [40:0] yf;
        logic [7:0]  n;
        logic [32:0] gap;
        logic [32:0] half;
        logic [7:0]  res;
        ex   = b[30:23];
        m    = {1'b1, b[22:0]};
        p    = '0;
        up   = 1'b0;
        keep = '0;
        xf   = '0;
        yf   = '0;
        n    = '0;
        gap  = '0;
        half = '0;
        res  = 8'd0;
        if (ex == 8'hFF && b[22:0] != 0) res = 8'd0;
        else if (b[31]) res = 8'd0;
        else if (ex >= 8'd127) res = 8'hFF;
        else if (ex >= 8'd118) begin
            // Below this exponent v*255+0.5 stays under one and gives zero.
            p = {m, 8'd0} - {8'd0, m};
            if (p[31]) begin
                up   = p[7] && (p[6:0] != 0 || p[8]);
                keep = {1'b0, p[31:8], 8'd0} + (up ? 33'h100 : 33'd0);
            end else begin
                up   = p[6] && (p[5:0] != 0 || p[7]);
                keep = {1'b0, p[31:7], 7'd0} + (up ? 33'h80 : 33'd0);
            end
            xf = {8'd0, keep} << (ex - 8'd118);
            yf = xf + 41'h0_8000_0000;
            n  = yf[39:32];
            gap = 33'h1_0000_0000 - {1'b0, yf[31:0]};
            // Half an ulp of the sum, in units of 2^-32.
            half = 33'h80;
            for (int i = 0; i < 8; i++) begin
                if (n[i]) half = 33'h100 << i;
            end
            res = n + {7'd0, gap <= half};
        end
        return res;
    endfunction

    function automatic logic [15:0] to_half(input logic [31:0] b);
        logic        s;
        logic [7:0]  ex;
        logic [22:0] man;
        logic [23:0] mm;
        logic [4:0]  sh;
        logic [23:0] r24;
        logic [15:0] r;
        s   = b[31];
        ex  = b[30:23];
        man = b[22:0];
        mm  = {1'b1, man};
        sh  = 5'd0;
        r24 = 24'd0;
        if (ex == 8'hFF)
            r = {s, 15'h7C00} | ((man != 0) ? 16'h0200 : 16'h0000);
        else if (ex >= 8'd143) r = {s, 15'h7C00};
        else if (ex <= 8'd112) begin
            if (ex < 8'd102) r = {s, 15'd0};
            else begin
                sh  = 5'(8'd113 - ex);
                r24 = (mm >> sh) + 24'h1000;
                if (r24[23]) r = {s, 15'h0400};
                else r = {s, 5'd0, r24[22:13]};
            end
        end else begin
            r24 = {1'b0, man} + 24'h1000;
            r = {s, 15'({5'(ex - 8'd112), 10'd0} + {4'd0, r24[23:13]})};
            if (r[14:0] > 15'h7C00) r = {s, 15'h7C00};
        end
        return r;
    endfunction

endpackage

/* rtl/core/vertex_attribute_packer_unit.sv */
// Vertex attribute packer: turns one vertex of raw binary32 attributes into
// one packed 32-byte vertex with unorm8 color and binary16 texture coordinates.
//
// Input channel: drive i_vtx and raise push; a transaction completes on a
// rising edge with push high and full low. Result channel: while empty is low
// the oldest packed vertex is on o_vtx; a transaction completes on a rising
// edge with pop high. The configuration channel writes one register per
// transaction (index 0..4; other indices are ignored) and is always ready.
// Configure only while the block is idle.
//
// One vertex is accepted every cycle while full is low. The front end tracks
// the running vertex index and classifies the vertex; a four-entry queue
// decouples it from the back end, whose single output register does the color
// and half conversion. An accepted vertex is written into the queue and then
// into the output register, and empty goes low once it is held there. When the
// receiver stalls, the output register and the queue fill and then full rises.
// Synchronous reset clears the index, empties the queue and output register and
// sets the configuration to defaults (all streams absent, vertex count one).
module vertex_attribute_packer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  vap_pkg::t_vtx_in              i_vtx,
    output logic                          empty,
    input  logic                          pop,
    output vap_pkg::t_vtx_out             o_vtx,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [vap_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  logic [vap_pkg::CfgDataBits-1:0] i_cfg_data
);
    import vap_pkg::*;

    logic        r_has_normals, r_has_colors, r_has_texcoords;
    logic [23:0] r_normal_count, r_vertex_count;
    t_job        front_job, q_job;
    logic        q_empty, take, acc;

    assign o_cfg_ready = 1'b1;
    assign acc = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_normals   <= 1'b0;
            r_normal_count  <= '0;
            r_has_colors    <= 1'b0;
            r_has_texcoords <= 1'b0;
            r_vertex_count  <= 24'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HAS_NORMALS:   r_has_normals   <= i_cfg_data[0];
                REG_NORMAL_COUNT:  r_normal_count  <= i_cfg_data[23:0];
                REG_HAS_COLORS:    r_has_colors    <= i_cfg_data[0];
                REG_HAS_TEXCOORDS: r_has_texcoords <= i_cfg_data[0];
                REG_VERTEX_COUNT:  r_vertex_count  <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    vap_front u_front (
        .i_clk, .i_rst_n, .i_valid(acc), .i_vtx,
        .i_has_normals(r_has_normals), .i_normal_count(r_normal_count),
        .i_has_colors(r_has_colors), .i_has_texcoords(r_has_texcoords),
        .i_vertex_count(r_vertex_count), .o_job(front_job)
    );

    vap_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(front_job), .o_full(full),
        .o_empty(q_empty), .i_pop(take), .o_job(q_job)
    );

    vap_back u_back (
        .i_clk, .i_rst_n, .i_valid(!q_empty), .o_take(take), .i_job(q_job),
        .o_empty(empty), .i_pop(pop), .o_vtx
    );
endmodule

/* rtl/core/vap_front.sv */
module vap_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  vap_pkg::t_vtx_in i_vtx,
    input  logic           i_has_normals,
    input  logic [23:0]    i_normal_count,
    input  logic           i_has_colors,
    input  logic           i_has_texcoords,
    input  logic [23:0]    i_vertex_count,
    output vap_pkg::t_job  o_job
);
    import vap_pkg::*;

    logic [23:0] r_index;
    logic [24:0] n_next;

    assign n_next = {1'b0, r_index} + 25'd1;
    assign o_job.vtx     = i_vtx;
    assign o_job.use_nrm = i_has_normals && (r_index < i_normal_count);
    assign o_job.use_col = i_has_colors;
    assign o_job.use_tex = i_has_texcoords;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
        end else if (i_valid) begin
            r_index <= (n_next >= {1'b0, i_vertex_count}) ? '0 : n_next[23:0];
        end
    end
endmodule

/* rtl/core/vap_queue.sv */
module vap_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vap_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output vap_pkg::t_job o_job
);
    import vap_pkg::*;

    localparam int AW = $clog2(QueueDepth);
    t_job          r_mem [QueueDepth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          wr, rd;

    assign o_full  = (r_cnt == (AW+1)'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign wr = i_push && !o_full;
    assign rd = i_pop && !o_empty;
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule

/* rtl/core/vap_back.sv */
module vap_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_take,
    input  vap_pkg::t_job    i_job,
    output logic             o_empty,
    input  logic             i_pop,
    output vap_pkg::t_vtx_out o_vtx
);
    import vap_pkg::*;

    logic     r_full;
    t_vtx_out r_out, n_out;
    logic [31:0] tu, tv;

    assign o_take  = i_valid && (!r_full || i_pop);
    assign o_empty = !r_full;
    assign o_vtx   = r_out;

    always_comb begin
        n_out.out_pos_x = i_job.vtx.pos_x;
        n_out.out_pos_y = i_job.vtx.pos_y;
        n_out.out_pos_z = i_job.vtx.pos_z;
        n_out.out_nrm_x = i_job.use_nrm ? i_job.vtx.nrm_x : 32'd0;
        n_out.out_nrm_y = i_job.use_nrm ? i_job.vtx.nrm_y : 32'd0;
        n_out.out_nrm_z = i_job.use_nrm ? i_job.vtx.nrm_z : FloatOne;
        n_out.out_color = i_job.use_col ?
            {unorm8(i_job.vtx.col_a), unorm8(i_job.vtx.col_b),
             unorm8(i_job.vtx.col_g), unorm8(i_job.vtx.col_r)} : 32'hFFFF_FFFF;
        tu = i_job.use_tex ? i_job.vtx.tex_u : 32'd0;
        tv = i_job.use_tex ? i_job.vtx.tex_v : 32'd0;
        n_out.out_texcoord = {to_half(tv), to_half(tu)};
    end

    always_ff @(posedge i_clk) begin
        if (o_take) r_out <= n_out;
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (o_take) begin
            r_full <= 1'b1;
        end else if (i_pop) begin
            r_full <= 1'b0;
        end
    end
endmodule

/* test/vertex_attribute_packer_unit_tb.sv */
module vertex_attribute_packer_unit_tb;
    import vap_pkg::*;

    // Clock, reset and the ports of the block under test.
    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_vtx_in     i_vtx;
    logic        empty;
    logic        pop;
    t_vtx_out    o_vtx;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CfgIdxBits-1:0]  i_cfg_index;
    logic [CfgDataBits-1:0] i_cfg_data;

    vertex_attribute_packer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_vtx       (i_vtx),
        .empty       (empty),
        .pop         (pop),
        .o_vtx       (o_vtx),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the configuration and of the running vertex index.
    logic        sh_has_normals;
    logic [23:0] sh_normal_count;
    logic        sh_has_colors;
    logic        sh_has_texcoords;
    logic [23:0] sh_vertex_count;
    logic [23:0] sh_vertex_index;

    t_vtx_in  vertices_to_send[$];
    t_vtx_out packed_expected[$];

    // Idle percentages per side; the phase sequence changes them.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    // Number of cycles the receiver should hold off pop in one stretch.
    int unsigned hold_request;
    int unsigned hold_left;

    int unsigned error_count;
    int unsigned vertices_accepted;
    int unsigned vertices_checked;
    int unsigned cycle_count;

    localparam int unsigned CycleLimit = 400000;

    // Round a non-negative fixed-point value to 24 significant bits, ties to even,
    // just as a binary32 operation would round its exact result.
    function automatic logic [79:0] round_to_single(input logic [79:0] x);
        int          msb;
        int          drop;
        logic [79:0] keep;
        logic [79:0] rest;
        logic [79:0] half;
        msb = -1;
        for (int i = 0; i < 80; i++) begin
            if (x[i]) msb = i;
        end
        if (msb <= 23) return x;
        drop = msb - 23;
        keep = x >> drop;
        rest = x & ((80'd1 << drop) - 80'd1);
        half = 80'd1 << (drop - 1);
        if (rest > half || (rest == half && keep[0])) keep = keep + 80'd1;
        return keep << drop;
    endfunction

    // Color channel to byte: clamp to [0,1], then v*255 and +0.5, each rounded to
    // single precision, then truncated. Values are held with 63 fraction bits.
    function automatic logic [7:0] color_to_byte(input logic [31:0] w);
        logic [7:0]  e;
        logic [79:0] x;
        int          sh;
        e = w[30:23];
        if (e == 8'hFF && w[22:0] != 23'd0) return 8'd0;
        if (w[31]) return 8'd0;
        if (e >= 8'd127) return 8'hFF;
        // Far below 1/510 the sum always rounds back to one half.
        if (e < 8'd87) return 8'd0;
        sh = int'(e) - 150 + 63;
        x = 80'({1'b1, w[22:0]}) * 80'd255;
        x = x << sh;
        x = round_to_single(x);
        x = x + (80'd1 << 62);
        x = round_to_single(x);
        return x[70:63];
    endfunction

    // Narrowing of binary32 to binary16 with round half up.
    function automatic logic [15:0] float_to_half(input logic [31:0] w);
        logic [31:0] sgn;
        logic [31:0] man;
        logic [31:0] r;
        int          hexp;
        sgn = {16'd0, w[31], 15'd0};
        man = {9'd0, w[22:0]};
        if (w[30:23] == 8'hFF) return 16'(sgn | 32'h7C00 | ((man != 0) ? 32'h0200 : 32'h0));
        hexp = int'(w[30:23]) - 127 + 15;
        if (hexp >= 31) return 16'(sgn | 32'h7C00);
        if (hexp <= 0) begin
            if (hexp < -10) return 16'(sgn);
            man = (man | 32'h80_0000) >> (1 - hexp);
            return 16'(sgn | (((man + 32'h1000) >> 13) & 32'h7FFF));
        end
        r = (32'(hexp) << 10) + ((man + 32'h1000) >> 13);
        if (r > 32'h7C00) r = 32'h7C00;
        return 16'(sgn | r);
    endfunction

    // Works out the packed vertex for one accepted input and steps the index.
    function automatic t_vtx_out pack_vertex(input t_vtx_in v);
        t_vtx_out    o;
        logic [31:0] u;
        logic [31:0] t;
        logic [24:0] nxt;
        o.out_pos_x = v.pos_x;
        o.out_pos_y = v.pos_y;
        o.out_pos_z = v.pos_z;
        if (sh_has_normals && sh_vertex_index < sh_normal_count) begin
            o.out_nrm_x = v.nrm_x;
            o.out_nrm_y = v.nrm_y;
            o.out_nrm_z = v.nrm_z;
        end else begin
            o.out_nrm_x = 32'd0;
            o.out_nrm_y = 32'd0;
            o.out_nrm_z = FloatOne;
        end
        if (sh_has_colors) begin
            o.out_color = {color_to_byte(v.col_a), color_to_byte(v.col_b),
                           color_to_byte(v.col_g), color_to_byte(v.col_r)};
        end else begin
            o.out_color = 32'hFFFF_FFFF;
        end
        u = sh_has_texcoords ? v.tex_u : 32'd0;
        t = sh_has_texcoords ? v.tex_v : 32'd0;
        o.out_texcoord = {float_to_half(t), float_to_half(u)};
        nxt = {1'b0, sh_vertex_index} + 25'd1;
        if (nxt >= {1'b0, sh_vertex_count}) nxt = 25'd0;
        sh_vertex_index = nxt[23:0];
        return o;
    endfunction

    // One binary32 word drawn from a mix of classes so that clamping, rounding
    // carries, subnormal halves, infinities and NaNs all show up often.
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0, 1: ;
            2: w[30:23] = 8'($urandom_range(101, 144));
            3: begin
                w[31]    = 1'b0;
                w[30:23] = 8'($urandom_range(110, 127));
            end
            4: w[30:23] = 8'($urandom_range(118, 126));
            5: w[30:23] = 8'hFF;
            6: w[30:23] = 8'h00;
            7: begin
                w[30:23] = 8'($urandom_range(100, 145));
                w[12:0]  = $urandom_range(0, 1) ? 13'h1000 : 13'h0FFF;
                if ($urandom_range(0, 1)) w[22:13] = 10'h3FF;
            end
            8: begin
                case ($urandom_range(0, 5))
                    0: w = 32'h0000_0000;
                    1: w = 32'h8000_0000;
                    2: w = 32'h3F80_0000;
                    3: w = 32'h7F80_0000;
                    4: w = 32'hFF80_0000;
                    default: w = 32'h7FC0_0000;
                endcase
            end
            default: w[30:23] = 8'($urandom_range(0, 1) ? 8'd126 : 8'd125);
        endcase
        return w;
    endfunction

    function automatic t_vtx_in pick_vertex();
        t_vtx_in v;
        v.pos_x = pick_word();
        v.pos_y = pick_word();
        v.pos_z = pick_word();
        v.nrm_x = pick_word();
        v.nrm_y = pick_word();
        v.nrm_z = pick_word();
        v.col_r = pick_word();
        v.col_g = pick_word();
        v.col_b = pick_word();
        v.col_a = pick_word();
        v.tex_u = pick_word();
        v.tex_v = pick_word();
        return v;
    endfunction

    // A vertex whose color and texture words are given and the rest random.
    function automatic t_vtx_in shaped_vertex(input logic [31:0] c, input logic [31:0] t);
        t_vtx_in v;
        v = pick_vertex();
        v.col_r = c;
        v.col_g = ~c;
        v.col_b = c ^ 32'h8000_0000;
        v.col_a = c;
        v.tex_u = t;
        v.tex_v = t ^ 32'h8000_0000;
        return v;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender: each transaction accepted by the block is predicted at the edge at
    // which it completes, then the next pending vertex is offered or the line idles.
    always @(posedge i_clk) begin
        t_vtx_out exp_vtx;
        int       next_pos;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            next_pos = 0;
            if (push && !full) begin
                exp_vtx = pack_vertex(vertices_to_send[0]);
                packed_expected.push_back(exp_vtx);
                vertices_accepted++;
                next_pos = 1;
            end
            // A vertex still waiting on full stays offered; otherwise idle at random.
            if (vertices_to_send.size() > next_pos &&
                ((push && full) || $urandom_range(0, 99) >= send_idle_pct)) begin
                push  <= 1'b1;
                i_vtx <= vertices_to_send[next_pos];
            end else begin
                push  <= 1'b0;
            end
            if (next_pos == 1) void'(vertices_to_send.pop_front());
        end
    end

    // Receiver: compares each popped vertex field by field with the oldest
    // expectation. A requested hold keeps pop low for a long stretch so that the
    // internal queue fills and full is seen by the sender.
    always @(posedge i_clk) begin
        t_vtx_out exp_vtx;
        logic [255:0] got_bits;
        logic [255:0] exp_bits;
        if (!i_rst_n) begin
            pop       <= 1'b0;
            hold_left <= 0;
        end else begin
            if (pop && !empty) begin
                if (packed_expected.size() == 0) begin
                    $display("%0t: packed vertex with no expectation: %h", $realtime, o_vtx);
                    error_count++;
                end else begin
                    exp_vtx  = packed_expected.pop_front();
                    got_bits = o_vtx;
                    exp_bits = exp_vtx;
                    for (int k = 0; k < 8; k++) begin
                        if (got_bits[255-32*k -: 32] !== exp_bits[255-32*k -: 32]) begin
                            $display("%0t: field %0d expected %h actual %h", $realtime, k,
                                     exp_bits[255-32*k -: 32], got_bits[255-32*k -: 32]);
                            error_count++;
                        end
                    end
                    vertices_checked++;
                end
            end
            if (hold_request != 0) begin
                hold_left    <= hold_request;
                hold_request = 0;
                pop          <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                pop       <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Writes one register; the shadow copy follows at the completing edge.
    // Valid stays high so back-to-back writes never drop it within one step.
    task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            REG_HAS_NORMALS:   sh_has_normals   = data[0];
            REG_NORMAL_COUNT:  sh_normal_count  = data[23:0];
            REG_HAS_COLORS:    sh_has_colors    = data[0];
            REG_HAS_TEXCOORDS: sh_has_texcoords = data[0];
            REG_VERTEX_COUNT:  sh_vertex_count  = data[23:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic hn, input logic [23:0] nc, input logic hc,
                              input logic ht, input logic [23:0] vc);
        write_reg(REG_HAS_NORMALS, {$urandom} & 32'hFFFF_FFFE | 32'(hn));
        write_reg(REG_NORMAL_COUNT, {8'($urandom), nc});
        write_reg(REG_HAS_COLORS, 32'(hc));
        write_reg(REG_HAS_TEXCOORDS, 32'(ht));
        write_reg(REG_VERTEX_COUNT, 32'(vc));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every vertex was accepted and every packed vertex has come back,
    // then lets a few cycles pass before the configuration may change.
    task automatic drain();
        while (vertices_to_send.size() != 0 || packed_expected.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_phase(input int n, input int unsigned s_idle,
                                input int unsigned r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < n; i++) vertices_to_send.push_back(pick_vertex());
        drain();
    endtask

    initial begin
        push             = 1'b0;
        pop              = 1'b0;
        i_vtx            = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        error_count      = 0;
        vertices_accepted = 0;
        vertices_checked = 0;
        cycle_count      = 0;
        hold_request     = 0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        sh_has_normals   = 1'b0;
        sh_normal_count  = 24'd0;
        sh_has_colors    = 1'b0;
        sh_has_texcoords = 1'b0;
        sh_vertex_count  = 24'd1;
        sh_vertex_index  = 24'd0;
        i_rst_n          = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: every stream absent, so defaults are returned.
        for (int i = 0; i < 3; i++) vertices_to_send.push_back(pick_vertex());
        drain();

        // All streams present with a short geometry so that the normal cutoff
        // and the index wrap both happen within the directed vertices.
        set_config(1'b1, 24'd5, 1'b1, 1'b1, 24'd8);
        // Write to an index outside the register map, which must be ignored.
        write_reg(3'd5, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'h0);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        vertices_to_send.push_back(shaped_vertex(32'h0000_0000, 32'h0000_0000));
        vertices_to_send.push_back(shaped_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        vertices_to_send.push_back(shaped_vertex(32'h3F80_0000, 32'h7F80_0000));
        vertices_to_send.push_back(shaped_vertex(32'h7FC0_0000, 32'h7FC0_0001));
        vertices_to_send.push_back(shaped_vertex(32'hBF80_0000, 32'hFF80_0000));
        vertices_to_send.push_back(shaped_vertex(32'h4000_0000, 32'h4780_0000));
        vertices_to_send.push_back(shaped_vertex(32'h3F00_0000, 32'h477F_F000));
        vertices_to_send.push_back(shaped_vertex(32'h3B80_8081, 32'h477F_E000));
        vertices_to_send.push_back(shaped_vertex(32'h3F7F_FFFF, 32'h3380_0000));
        vertices_to_send.push_back(shaped_vertex(32'h3C00_0000, 32'h3300_0000));
        vertices_to_send.push_back(shaped_vertex(32'h0000_0001, 32'h387F_F000));
        vertices_to_send.push_back(shaped_vertex(32'h7F80_0000, 32'h3F80_1000));
        vertices_to_send.push_back(shaped_vertex(32'h3E80_0000, 32'h3F80_0FFF));
        vertices_to_send.push_back(shaped_vertex(32'h3F7F_8000, 32'h3FFF_F000));
        vertices_to_send.push_back(shaped_vertex(32'h8000_0000, 32'h8000_0000));
        vertices_to_send.push_back(shaped_vertex(32'h3A80_0000, 32'h3480_1000));
        drain();

        // Vertex count zero keeps the index at zero; normals always supplied.
        set_config(1'b1, 24'hFF_FFFF, 1'b1, 1'b0, 24'd0);
        random_phase(150, 0, 0);

        // No normal ever supplied although the stream is present.
        set_config(1'b1, 24'd0, 1'b0, 1'b1, 24'hFF_FFFF);
        random_phase(150, 87, 0);

        // Shrunk vertex count below the current index forces a wrap.
        set_config(1'b0, 24'd3, 1'b1, 1'b1, 24'd2);
        random_phase(150, 0, 87);

        set_config(1'b1, 24'd17, 1'b1, 1'b1, 24'd40);
        random_phase(150, 10, 10);

        // Long receiver stall with the sender running free so that full rises.
        set_config(1'b1, 24'd1, 1'b0, 1'b0, 24'd3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 60; i++) vertices_to_send.push_back(pick_vertex());
        hold_request = 40;
        drain();

        // Randomized settings for the remainder.
        for (int p = 0; p < 4; p++) begin
            set_config(1'($urandom), 24'($urandom_range(0, 50)), 1'($urandom),
                       1'($urandom), 24'($urandom_range(1, 60)));
            random_phase(60, (p % 2) ? 87 : 0, (p / 2) ? 87 : 10);
        end

        repeat (10) @(posedge i_clk);
        $display("Covered %0d vertices over stream, count and wrap settings,", vertices_accepted);
        $display("with sender idling, receiver stalling and a full-queue stretch.");
        if (error_count == 0 && packed_expected.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* vertex_attribute_packer_unit.f */
rtl/core/vap_pkg.sv
rtl/core/vap_front.sv
rtl/core/vap_queue.sv
rtl/core/vap_back.sv
rtl/core/vertex_attribute_packer_unit.sv
test/vertex_attribute_packer_unit_tb.sv
